FILE: rtl/core/vcsh_pkg.sv
// Shared types and constants for the view cone segment hit unit.
// No dependencies; used by vcsh_trig and the top level.
package vcsh_pkg;

   localparam logic [15:0] QUARTER_TURN = 16'd23040;
   localparam logic [31:0] ANG_K        = 32'd74961321;
   localparam int          TRIG_W       = 17;
   localparam logic [5:0]  STEP_LAST    = 6'd33;
   localparam logic [2:0]  TERM_LAST    = 3'd7;

   typedef enum logic [3:0] {
      T_IDLE,
      T_REDUCE,
      T_MUL_RK,
      T_LOAD_XX,
      T_MUL_XX,
      T_LOAD_SER,
      T_SER_MUL,
      T_DIV_LOAD,
      T_SER_DIV,
      T_ACCUM,
      T_ROUND,
      T_FINISH
   } trig_state_type;

   typedef struct packed {
      logic                     busy;
      logic signed [TRIG_W-1:0] cos_half;
      logic signed [TRIG_W-1:0] sin_half;
   } trig_type;

   // Series divisors: sine uses (2k)(2k+1), cosine (2k-1)(2k).
   // Return ceil(2^42 / d); exact floor division of any 34-bit value by d.
   function automatic logic [41:0] series_recip(input logic is_cos, input logic [2:0] k);
      logic [41:0] m;
      m = 42'd0;
      if (!is_cos) begin
         case (k)
            3'd1:    m = 42'd733007751851;
            3'd2:    m = 42'd219902325556;
            3'd3:    m = 42'd104715393122;
            3'd4:    m = 42'd61083979321;
            3'd5:    m = 42'd39982241011;
            3'd6:    m = 42'd28192605841;
            3'd7:    m = 42'd20943078625;
            default: m = 42'd0;
         endcase
      end else begin
         case (k)
            3'd1:    m = 42'd2199023255552;
            3'd2:    m = 42'd366503875926;
            3'd3:    m = 42'd146601550371;
            3'd4:    m = 42'd78536544842;
            3'd5:    m = 42'd48867183457;
            3'd6:    m = 42'd33318534176;
            3'd7:    m = 42'd24165090721;
            default: m = 42'd0;
         endcase
      end
      return m;
   endfunction

endpackage

FILE: rtl/core/vcsh_trig.sv
// Half-angle cosine and sine derivation on a view angle write.
// Shared bit-serial multiplier, also used for division by reciprocal; depends on vcsh_pkg.
module vcsh_trig (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   output vcsh_pkg::trig_type trig
);

   vcsh_pkg::trig_state_type state_ff, state_in;
   logic [15:0]        ang_ff, ang_in;
   logic [1:0]         quad_ff, quad_in;
   logic [33:0]        mul_a_ff, mul_a_in;
   logic [41:0]        mul_b_ff, mul_b_in;
   logic [75:0]        acc_ff, acc_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [31:0]        x_ff, x_in;
   logic [31:0]        x2_ff, x2_in;
   logic signed [35:0] sum_ff, sum_in;
   logic               sel_ff, sel_in;
   logic [2:0]         k_ff, k_in;
   logic [15:0]        s_ff, s_in;
   logic [15:0]        c_ff, c_in;
   logic signed [16:0] cos_ff, cos_in;
   logic signed [16:0] sin_ff, sin_in;

   logic [75:0]        acc_step;
   logic [41:0]        recip;
   logic [33:0]        quot;
   logic [31:0]        x_calc;
   logic [31:0]        x2_calc;
   logic [30:0]        clamped;
   logic [15:0]        rounded;
   logic signed [16:0] c17, s17;

   always_comb begin
      acc_step = {acc_ff[74:0], 1'b0} + (mul_a_ff[33] ? {34'd0, mul_b_ff} : 76'd0);
      recip    = vcsh_pkg::series_recip(sel_ff, k_ff);
      quot     = acc_ff[75:42];
      x_calc   = 32'((acc_ff[41:0] + 42'd512) >> 10);
      x2_calc  = 32'((acc_ff[61:0] + 62'd536870912) >> 30);
      if (sum_ff < 0) begin
         clamped = 31'd0;
      end else if (sum_ff > 36'sd1073741824) begin
         clamped = 31'd1073741824;
      end else begin
         clamped = 31'(sum_ff);
      end
      rounded = 16'((clamped + 31'd16384) >> 15);
      c17     = $signed({1'b0, c_ff});
      s17     = $signed({1'b0, s_ff});
   end

   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      quad_in  = quad_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      sum_in   = sum_ff;
      sel_in   = sel_ff;
      k_in     = k_ff;
      s_in     = s_ff;
      c_in     = c_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      if (csr_wr_en) begin
         ang_in   = csr_wr_data;
         quad_in  = 2'd0;
         state_in = vcsh_pkg::T_REDUCE;
      end else begin
         unique case (state_ff)
            vcsh_pkg::T_IDLE: begin
            end
            vcsh_pkg::T_REDUCE: begin
               if (ang_ff >= vcsh_pkg::QUARTER_TURN) begin
                  ang_in  = ang_ff - vcsh_pkg::QUARTER_TURN;
                  quad_in = quad_ff + 2'd1;
               end else begin
                  mul_a_in = {18'd0, ang_ff};
                  mul_b_in = {10'd0, vcsh_pkg::ANG_K};
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = vcsh_pkg::T_MUL_RK;
               end
            end
            vcsh_pkg::T_MUL_RK, vcsh_pkg::T_MUL_XX, vcsh_pkg::T_SER_MUL,
            vcsh_pkg::T_SER_DIV: begin
               acc_in   = acc_step;
               mul_a_in = {mul_a_ff[32:0], 1'b0};
               cnt_in   = cnt_ff + 6'd1;
               if (cnt_ff == vcsh_pkg::STEP_LAST) begin
                  if (state_ff == vcsh_pkg::T_MUL_RK) begin
                     state_in = vcsh_pkg::T_LOAD_XX;
                  end else if (state_ff == vcsh_pkg::T_MUL_XX) begin
                     state_in = vcsh_pkg::T_LOAD_SER;
                  end else if (state_ff == vcsh_pkg::T_SER_MUL) begin
                     state_in = vcsh_pkg::T_DIV_LOAD;
                  end else begin
                     state_in = vcsh_pkg::T_ACCUM;
                  end
               end
            end
            vcsh_pkg::T_LOAD_XX: begin
               x_in     = x_calc;
               mul_a_in = {2'd0, x_calc};
               mul_b_in = {10'd0, x_calc};
               acc_in   = '0;
               cnt_in   = '0;
               state_in = vcsh_pkg::T_MUL_XX;
            end
            vcsh_pkg::T_LOAD_SER: begin
               x2_in    = x2_calc;
               sel_in   = 1'b0;
               k_in     = 3'd1;
               sum_in   = $signed({4'd0, x_ff});
               mul_a_in = {2'd0, x_ff};
               mul_b_in = {10'd0, x2_calc};
               acc_in   = '0;
               cnt_in   = '0;
               state_in = vcsh_pkg::T_SER_MUL;
            end
            vcsh_pkg::T_DIV_LOAD: begin
               mul_a_in = acc_ff[63:30];
               mul_b_in = recip;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = vcsh_pkg::T_SER_DIV;
            end
            vcsh_pkg::T_ACCUM: begin
               sum_in = k_ff[0] ? sum_ff - $signed({2'd0, quot})
                                : sum_ff + $signed({2'd0, quot});
               if (k_ff == vcsh_pkg::TERM_LAST) begin
                  state_in = vcsh_pkg::T_ROUND;
               end else begin
                  k_in     = k_ff + 3'd1;
                  mul_a_in = quot;
                  mul_b_in = {10'd0, x2_ff};
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = vcsh_pkg::T_SER_MUL;
               end
            end
            vcsh_pkg::T_ROUND: begin
               if (!sel_ff) begin
                  s_in     = rounded;
                  sel_in   = 1'b1;
                  k_in     = 3'd1;
                  sum_in   = 36'sd1073741824;
                  mul_a_in = 34'd1073741824;
                  mul_b_in = {10'd0, x2_ff};
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = vcsh_pkg::T_SER_MUL;
               end else begin
                  c_in     = rounded;
                  state_in = vcsh_pkg::T_FINISH;
               end
            end
            vcsh_pkg::T_FINISH: begin
               case (quad_ff)
                  2'd0: begin
                     cos_in = c17;
                     sin_in = s17;
                  end
                  2'd1: begin
                     cos_in = -s17;
                     sin_in = c17;
                  end
                  2'd2: begin
                     cos_in = -c17;
                     sin_in = -s17;
                  end
                  default: begin
                     cos_in = s17;
                     sin_in = -c17;
                  end
               endcase
               state_in = vcsh_pkg::T_IDLE;
            end
            default: state_in = vcsh_pkg::T_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vcsh_pkg::T_IDLE;
         cos_ff   <= 17'sd32768;
         sin_ff   <= 17'sd0;
      end else begin
         state_ff <= state_in;
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff   <= ang_in;
      quad_ff  <= quad_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      sum_ff   <= sum_in;
      sel_ff   <= sel_in;
      k_ff     <= k_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
   end

   assign trig.busy     = (state_ff != vcsh_pkg::T_IDLE) || csr_wr_en;
   assign trig.cos_half = cos_ff;
   assign trig.sin_half = sin_ff;

endmodule

FILE: rtl/core/vcsh_edge.sv
// Three-stage hit test of one cone edge ray against the segment line.
// Takes origin-relative endpoint data and the rotated ray; depends on nothing.
module vcsh_edge #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH:0]   p1x,
   input  logic signed [COORD_WIDTH:0]   p1y,
   input  logic signed [COORD_WIDTH+1:0] ddx,
   input  logic signed [COORD_WIDTH+1:0] ddy,
   input  logic signed [COORD_WIDTH+17:0] vx,
   input  logic signed [COORD_WIDTH+17:0] vy,
   input  logic                          tn_neg,
   input  logic                          tn_zero,
   output logic                          out_valid,
   output logic                          hit
);

   localparam int PW = 2 * COORD_WIDTH + 20;
   localparam int DW = PW + 1;
   localparam int MW = PW + 2;

   logic v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] vxdy_ff, vydx_ff, p1xvy_ff, p1yvx_ff;
   logic signed [DW-1:0] den_ff, den_in;
   logic signed [DW-1:0] sn_ff, sn_in;
   logic signed [MW-1:0] dms;
   logic tn_neg1_ff, tn_zero1_ff, tn_neg2_ff, tn_zero2_ff;
   logic hit_ff, hit_in;

   always_comb begin
      den_in = DW'(vxdy_ff) - DW'(vydx_ff);
      sn_in  = DW'(p1xvy_ff) - DW'(p1yvx_ff);
      dms    = MW'(den_ff) - MW'(sn_ff);
      hit_in = (den_ff != '0) && !tn_zero2_ff && (sn_ff != '0) && (dms != '0)
               && (tn_neg2_ff == den_ff[DW-1]) && (sn_ff[DW-1] == den_ff[DW-1])
               && (dms[MW-1] == den_ff[DW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      vxdy_ff     <= PW'(vx) * PW'(ddy);
      vydx_ff     <= PW'(vy) * PW'(ddx);
      p1xvy_ff    <= PW'(p1x) * PW'(vy);
      p1yvx_ff    <= PW'(p1y) * PW'(vx);
      tn_neg1_ff  <= tn_neg;
      tn_zero1_ff <= tn_zero;
      den_ff      <= den_in;
      sn_ff       <= sn_in;
      tn_neg2_ff  <= tn_neg1_ff;
      tn_zero2_ff <= tn_zero1_ff;
      hit_ff      <= hit_in;
   end

   assign out_valid = v3_ff;
   assign hit       = hit_ff;

endmodule

FILE: rtl/core/view_cone_segment_hits_unit.sv
// View cone segment hit unit: top level.
// Uses vcsh_pkg, vcsh_trig and two vcsh_edge pipelines.
//
// Usage: write the full cone angle (1/128 degree) on csr_wr_en/csr_wr_data.
// The write starts a derivation of cos and sin of the half angle in a shared
// bit-serial multiplier that also divides by reciprocal multiplication; busy
// stays high through range reduction, two multiplies, then fourteen series terms
// and the final rounding.
// A beat is taken at a rising edge with start high and busy low. Beats may
// follow in every cycle: the pipeline has seven register stages (offsets,
// rotate and cross products, ray sums, the three vcsh_edge stages, output),
// the first loaded by the edge that takes the beat; rsp_valid is high for
// one cycle as the beat leaves the output stage. Throughput is one beat per
// cycle while busy is low, set by the fully pipelined multipliers of the rotate and cross-product stages.
// The receiver cannot stall; results must be taken when rsp_valid is high.
// Reset clears all valid bits, sets the angle to zero (cos 1, sin 0) and
// leaves busy low.
module view_cone_segment_hits_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic                          csr_wr_en,
   input  logic [15:0]                   csr_wr_data,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_hit_count,
   output logic                          rsp_minus_edge_hit,
   output logic                          rsp_plus_edge_hit
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = W + 1;
   localparam int DW = W + 2;
   localparam int RW = W + 17;
   localparam int VW = W + 18;
   localparam int TW = 2 * W + 2;
   localparam int NW = 2 * W + 3;

   vcsh_pkg::trig_type trig;

   logic accept;
   logic v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [PW-1:0] p1x2_ff, p1y2_ff, p1x3_ff, p1y3_ff;
   logic signed [DW-1:0] ddx_ff, ddy_ff, ddx2_ff, ddy2_ff, ddx3_ff, ddy3_ff;
   logic signed [W-1:0]  dirx_ff, diry_ff;
   logic signed [RW-1:0] dxc_ff, dys_ff, dxs_ff, dyc_ff;
   logic signed [TW-1:0] t1_ff, t2_ff;
   logic signed [VW-1:0] mvx_ff, mvy_ff, pvx_ff, pvy_ff;
   logic signed [NW-1:0] tn_ff, tn_in;
   logic minus_valid, plus_valid, minus_hit, plus_hit;
   logic out_valid_ff;
   logic [1:0] count_ff;
   logic minus_ff, plus_ff;

   vcsh_trig u_trig (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .trig        (trig)
   );

   assign busy   = trig.busy;
   assign accept = start && !busy;
   assign tn_in  = NW'(t1_ff) - NW'(t2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= minus_valid && plus_valid;
      end
   end

   always_ff @(posedge clock) begin
      p1x_ff  <= PW'(req_seg_start_x) - PW'(req_origin_x);
      p1y_ff  <= PW'(req_seg_start_y) - PW'(req_origin_y);
      p2x_ff  <= PW'(req_seg_end_x) - PW'(req_origin_x);
      p2y_ff  <= PW'(req_seg_end_y) - PW'(req_origin_y);
      ddx_ff  <= DW'(req_seg_end_x) - DW'(req_seg_start_x);
      ddy_ff  <= DW'(req_seg_end_y) - DW'(req_seg_start_y);
      dirx_ff <= req_dir_x;
      diry_ff <= req_dir_y;

      dxc_ff  <= RW'(dirx_ff) * RW'(trig.cos_half);
      dys_ff  <= RW'(diry_ff) * RW'(trig.sin_half);
      dxs_ff  <= RW'(dirx_ff) * RW'(trig.sin_half);
      dyc_ff  <= RW'(diry_ff) * RW'(trig.cos_half);
      t1_ff   <= TW'(p1x_ff) * TW'(p2y_ff);
      t2_ff   <= TW'(p2x_ff) * TW'(p1y_ff);
      p1x2_ff <= p1x_ff;
      p1y2_ff <= p1y_ff;
      ddx2_ff <= ddx_ff;
      ddy2_ff <= ddy_ff;

      mvx_ff  <= VW'(dxc_ff) + VW'(dys_ff);
      mvy_ff  <= VW'(dyc_ff) - VW'(dxs_ff);
      pvx_ff  <= VW'(dxc_ff) - VW'(dys_ff);
      pvy_ff  <= VW'(dxs_ff) + VW'(dyc_ff);
      tn_ff   <= tn_in;
      p1x3_ff <= p1x2_ff;
      p1y3_ff <= p1y2_ff;
      ddx3_ff <= ddx2_ff;
      ddy3_ff <= ddy2_ff;

      count_ff <= {1'b0, minus_hit} + {1'b0, plus_hit};
      minus_ff <= minus_hit;
      plus_ff  <= plus_hit;
   end

   vcsh_edge #(.COORD_WIDTH(COORD_WIDTH)) u_minus_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .p1x       (p1x3_ff),
      .p1y       (p1y3_ff),
      .ddx       (ddx3_ff),
      .ddy       (ddy3_ff),
      .vx        (mvx_ff),
      .vy        (mvy_ff),
      .tn_neg    (tn_ff[NW-1]),
      .tn_zero   (tn_ff == '0),
      .out_valid (minus_valid),
      .hit       (minus_hit)
   );

   vcsh_edge #(.COORD_WIDTH(COORD_WIDTH)) u_plus_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .p1x       (p1x3_ff),
      .p1y       (p1y3_ff),
      .ddx       (ddx3_ff),
      .ddy       (ddy3_ff),
      .vx        (pvx_ff),
      .vy        (pvy_ff),
      .tn_neg    (tn_ff[NW-1]),
      .tn_zero   (tn_ff == '0),
      .out_valid (plus_valid),
      .hit       (plus_hit)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_hit_count      = count_ff;
   assign rsp_minus_edge_hit = minus_ff;
   assign rsp_plus_edge_hit  = plus_ff;

endmodule
